// ===== hw/rtl/half_step_stepper_positioner_core_macros.svh =====
// ----------------------------------------------------------------------------
// Half-step stepper positioner: assertion macros
// Shared assertion forms for the checker of the positioner core.
// ----------------------------------------------------------------------------
`ifndef HALF_STEP_STEPPER_POSITIONER_CORE_MACROS_SVH
`define HALF_STEP_STEPPER_POSITIONER_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define HSSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HSSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/hssp_pkg.sv =====
// ----------------------------------------------------------------------------
// Half-step stepper positioner package
// Widths, opcodes, interface structs and the half-step coil table.
// ----------------------------------------------------------------------------
package hssp_pkg;

    localparam int MOTORS     = 3;
    localparam int REPORTED   = 3;
    localparam int POS_W      = 16;
    localparam int HOLD_W     = 15;
    localparam int COIL_W     = 4;
    localparam int IDX_W      = 2;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 15'd1000;

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_SET_DEST = 1'b1;

    typedef struct packed {
        logic                    tick;
        logic                    dest_we;
        logic signed [POS_W-1:0] dest;
    } t_motor_ctrl;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic              at_target;
    } t_motor_status;

    // Half-step sequence: one coil, two coils, one coil, and so on.
    function automatic logic [COIL_W-1:0] half_step(input logic [2:0] phase);
        logic [COIL_W-1:0] pat;
        unique case (phase)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            3'd7:    pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

// ===== hw/rtl/hssp_motor.sv =====
// ----------------------------------------------------------------------------
// Half-step stepper positioner: one motor
// Holds position, destination, idle count and coil drive of one motor and
// presents the coil drive and at-target flag that follow the current update.
// ----------------------------------------------------------------------------
module hssp_motor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hssp_pkg::t_motor_ctrl        i_ctrl,
    input  logic [hssp_pkg::HOLD_W-1:0]  i_hold_limit,
    output hssp_pkg::t_motor_status      o_status
);
    import hssp_pkg::*;

    localparam logic signed [POS_W-1:0] STEP = POS_W'(1);

    logic signed [POS_W-1:0] r_pos,  n_pos;
    logic signed [POS_W-1:0] r_dest, n_dest;
    logic [HOLD_W-1:0]       r_idle, n_idle;
    logic [COIL_W-1:0]       r_coils, n_coils;
    logic                    w_at;

    assign w_at = (r_pos == r_dest);

    always_comb begin
        n_pos   = r_pos;
        n_dest  = r_dest;
        n_idle  = r_idle;
        n_coils = r_coils;
        if (i_ctrl.dest_we) begin
            n_dest = i_ctrl.dest;
        end
        if (i_ctrl.tick) begin
            if (w_at) begin
                // Hold the last pattern until the idle count reaches the limit.
                if (r_idle >= i_hold_limit) begin
                    n_coils = '0;
                end else begin
                    n_idle = r_idle + 1'b1;
                end
            end else begin
                n_idle = '0;
                if (r_pos < r_dest) begin
                    n_pos = r_pos + STEP;
                end else begin
                    n_pos = r_pos - STEP;
                end
                n_coils = half_step(n_pos[2:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_dest  <= '0;
            r_idle  <= '0;
            r_coils <= '0;
        end else begin
            r_pos   <= n_pos;
            r_dest  <= n_dest;
            r_idle  <= n_idle;
            r_coils <= n_coils;
        end
    end

    assign o_status.coils     = n_coils;
    assign o_status.at_target = (n_pos == n_dest);

endmodule

// ===== hw/rtl/half_step_stepper_positioner_core.sv =====
// ----------------------------------------------------------------------------
// Half-step stepper positioner core
// Drives the coils of several four-coil stepper motors in half-step mode.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is either a tick, which steps every motor
// not at its destination toward it, or a set-destination command for one motor.
// Every input transfer gives exactly one result: the coil pattern of motors 0
// to 2 and their at-target mask. An item waits in the input register and is
// applied to the motor state as the result register loads, so a result passes
// through the input register and then the result register. One item is taken
// per cycle while the result channel does not stall, and the input register
// also holds one item while a result waits to be taken.
// The hold limit is written through the configuration channel, which is always
// ready; write it only while no item is in flight.
module half_step_stepper_positioner_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hssp_pkg::HOLD_W-1:0]      i_cfg_hold_limit,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_op,
    input  logic [hssp_pkg::IDX_W-1:0]       i_motor_index,
    input  logic signed [hssp_pkg::POS_W-1:0] i_target_position,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [hssp_pkg::COIL_W-1:0]      o_coils_motor0,
    output logic [hssp_pkg::COIL_W-1:0]      o_coils_motor1,
    output logic [hssp_pkg::COIL_W-1:0]      o_coils_motor2,
    output logic [hssp_pkg::REPORTED-1:0]    o_at_target_mask
);
    import hssp_pkg::*;

    logic [HOLD_W-1:0]       r_hold_limit;

    logic                    r_in_valid;
    logic                    r_op;
    logic [IDX_W-1:0]        r_motor_index;
    logic signed [POS_W-1:0] r_target;

    logic                    r_out_valid;
    logic [COIL_W-1:0]       r_coils [REPORTED];
    logic [REPORTED-1:0]     r_mask;

    logic                    w_adv;
    logic                    w_in_take;
    t_motor_ctrl             w_ctrl [MOTORS];
    t_motor_status           w_stat [MOTORS];
    logic [COIL_W-1:0]       w_coils [REPORTED];
    logic [REPORTED-1:0]     w_mask;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_limit <= HOLD_RESET;
        end else if (i_cfg_valid) begin
            r_hold_limit <= i_cfg_hold_limit;
        end
    end

    // The held item moves on whenever the result register is free or drains.
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_in_take  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op          <= i_op;
            r_motor_index <= i_motor_index;
            r_target      <= i_target_position;
        end
    end

    for (genvar m = 0; m < MOTORS; m++) begin : g_motor
        assign w_ctrl[m].tick    = w_adv && (r_op == OP_TICK);
        assign w_ctrl[m].dest_we = w_adv && (r_op == OP_SET_DEST)
                                   && (32'(r_motor_index) == 32'(m));
        assign w_ctrl[m].dest    = r_target;

        hssp_motor u_motor (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl[m]),
            .i_hold_limit (r_hold_limit),
            .o_status     (w_stat[m])
        );
    end

    // Motors that are not built report no coils and are never at target.
    for (genvar r = 0; r < REPORTED; r++) begin : g_report
        if (r < MOTORS) begin : g_present
            assign w_coils[r] = w_stat[r].coils;
            assign w_mask[r]  = w_stat[r].at_target;
        end else begin : g_absent
            assign w_coils[r] = '0;
            assign w_mask[r]  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_coils <= w_coils;
            r_mask  <= w_mask;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_coils_motor0   = r_coils[0];
    assign o_coils_motor1   = r_coils[1];
    assign o_coils_motor2   = r_coils[2];
    assign o_at_target_mask = r_mask;

endmodule

// ===== hw/rtl/hssp_checker.sv =====
// ----------------------------------------------------------------------------
// Half-step stepper positioner checker
// Port-level checks on the positioner core, attached by bind.
// ----------------------------------------------------------------------------
`include "half_step_stepper_positioner_core_macros.svh"

module hssp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_cfg_ready,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [hssp_pkg::COIL_W-1:0]     o_coils_motor0,
    input logic [hssp_pkg::REPORTED-1:0]   o_at_target_mask
);
    import hssp_pkg::*;

    // Reset empties the result register.
    `HSSP_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // With the result register empty, the input side can never stall.
    `HSSP_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "input stalled with no result pending")

    // A stalled result holds its value.
    `HSSP_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_coils_motor0) && $stable(o_at_target_mask), "stalled result changed")

    // Configuration writes are never refused.
    `HSSP_ASSERT(a_cfg_ready, i_clk, i_rst_n, o_cfg_ready, "configuration channel not ready")

endmodule

bind half_step_stepper_positioner_core hssp_checker u_hssp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_cfg_ready      (o_cfg_ready),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_coils_motor0   (o_coils_motor0),
    .o_at_target_mask (o_at_target_mask)
);
